// ===== hw/rtl/cvs_pkg.sv =====
package cvs_pkg;

  localparam int PIX_W       = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = PIX_W + COEF_W;
  localparam int SIZE_W      = 9;
  localparam int STRIDE_W    = 4;
  localparam int IDX_W       = 8;
  localparam int VALUE_W     = 24;
  localparam int KROWS       = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int REG_SEL_LSB = 3;
  localparam int REG_SEL_W   = CFG_ADDR_W - REG_SEL_LSB;
  localparam int SIZE_RESET   = 28;
  localparam int STRIDE_RESET = 1;
  localparam int FRAC_SHIFT   = 14;
  localparam int ACC_W        = 40;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = 1;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-8388608);

  typedef enum logic [REG_SEL_W-1:0] {
    REG_IMAGE_SIZE = 3'd0,
    REG_STRIDE     = 3'd1,
    REG_KROW0      = 3'd2,
    REG_KROW1      = 3'd3,
    REG_KROW2      = 3'd4,
    REG_KROW3      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   image_size;
    logic [STRIDE_W-1:0] stride;
    logic                restart;
  } cfg_t;

  typedef logic [KROWS-1:0][CFG_DATA_W-1:0] kernel_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic             last;
  } meta_t;

endpackage

// ===== hw/rtl/conv2d_valid_stride.sv =====
// Streaming 2-D correlation (no padding) of a square image with a
// KERNEL_SIZE x KERNEL_SIZE kernel of signed Q2.14 coefficients. Pixels (signed
// Q8.8) enter in raster order at one per clock; KERNEL_SIZE-1 line memories of
// MAX_IMAGE_SIZE words each keep the rows above. For every window whose origin
// lies on a stride multiple a result word leaves with value (Q16.8, floor,
// saturated to 24 bits), output row and column, and tlast on the final window.
// Sustained rate is one pixel per cycle, set by the line-memory read/write and
// window shift in the front stage; the front stalls only when a window must be
// pushed while its two-entry window queue is full. The multiply-accumulate back
// end has one multiplier per tap and four register stages: products, row sums,
// total and output. Writing image_size or stride restarts the image at row 0,
// column 0.
module conv2d_valid_stride #(
  parameter int KERNEL_SIZE    = 3,
  parameter int MAX_IMAGE_SIZE = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // pixel[15:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata,   // value[23:0], out_row[31:24], out_col[39:32]
  output logic                            m_axis_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cvs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cvs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cvs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import cvs_pkg::*;

  localparam int WIN_W = KERNEL_SIZE * KERNEL_SIZE * PIX_W;
  localparam int JOB_W = WIN_W + $bits(meta_t);

  cfg_t               cfg;
  kernel_t            kernel;
  logic               job_push, job_full, job_pop, job_empty;
  logic [WIN_W-1:0]   front_win, back_win;
  meta_t              front_meta, back_meta, out_meta;
  logic [JOB_W-1:0]   q_din, q_dout;
  logic [VALUE_W-1:0] out_value;

  cvs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .kernel  (kernel)
  );

  cvs_front #(
    .KERNEL_SIZE    (KERNEL_SIZE),
    .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (s_axis_tvalid),
    .pix_ready (s_axis_tready),
    .pix       (s_axis_tdata),
    .job_push  (job_push),
    .job_win   (front_win),
    .job_meta  (front_meta),
    .job_full  (job_full)
  );

  assign q_din = {front_meta, front_win};

  cvs_fifo #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (q_din),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (q_dout),
    .empty (job_empty)
  );

  assign back_win  = q_dout[WIN_W-1:0];
  assign back_meta = meta_t'(q_dout[JOB_W-1:WIN_W]);

  cvs_back #(
    .KERNEL_SIZE (KERNEL_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .kernel    (kernel),
    .job_valid (!job_empty),
    .job_pop   (job_pop),
    .job_win   (back_win),
    .job_meta  (back_meta),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (out_value),
    .out_meta  (out_meta)
  );

  assign m_axis_tdata = {out_meta.out_col, out_meta.out_row, out_value};
  assign m_axis_tlast = out_meta.last;

endmodule

// ===== hw/rtl/cvs_regs.sv =====
module cvs_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cvs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cvs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cvs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output cvs_pkg::cfg_t                   cfg,
  output cvs_pkg::kernel_t                kernel
);
  import cvs_pkg::*;

  logic                 wr_en;
  logic [REG_SEL_W-1:0] sel;
  logic [SIZE_W-1:0]    image_size;
  logic [STRIDE_W-1:0]  stride;
  kernel_t              krows;

  assign pready = 1'b1;
  assign sel    = paddr[CFG_ADDR_W-1:REG_SEL_LSB];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= SIZE_W'(SIZE_RESET);
      stride     <= STRIDE_W'(STRIDE_RESET);
      krows      <= '0;
    end else if (wr_en) begin
      case (sel)
        REG_IMAGE_SIZE: image_size <= pwdata[SIZE_W-1:0];
        REG_STRIDE:     stride     <= pwdata[STRIDE_W-1:0];
        REG_KROW0:      krows[0]   <= pwdata;
        REG_KROW1:      krows[1]   <= pwdata;
        REG_KROW2:      krows[2]   <= pwdata;
        REG_KROW3:      krows[3]   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_IMAGE_SIZE: prdata = CFG_DATA_W'(image_size);
      REG_STRIDE:     prdata = CFG_DATA_W'(stride);
      REG_KROW0:      prdata = krows[0];
      REG_KROW1:      prdata = krows[1];
      REG_KROW2:      prdata = krows[2];
      REG_KROW3:      prdata = krows[3];
      default:        prdata = '0;
    endcase
  end

  // size or stride write restarts the image position in the same edge
  assign cfg.image_size = image_size;
  assign cfg.stride     = stride;
  assign cfg.restart    = wr_en && ((sel == REG_IMAGE_SIZE) || (sel == REG_STRIDE));
  assign kernel         = krows;

endmodule

// ===== hw/rtl/cvs_front.sv =====
module cvs_front #(
  parameter int KERNEL_SIZE    = 3,
  parameter int MAX_IMAGE_SIZE = 256
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  cvs_pkg::cfg_t                                    cfg,
  input  logic                                             pix_valid,
  output logic                                             pix_ready,
  input  logic [cvs_pkg::PIX_W-1:0]                        pix,
  output logic                                             job_push,
  output logic [KERNEL_SIZE*KERNEL_SIZE*cvs_pkg::PIX_W-1:0] job_win,
  output cvs_pkg::meta_t                                   job_meta,
  input  logic                                             job_full
);
  import cvs_pkg::*;

  localparam int CW = $clog2(MAX_IMAGE_SIZE);
  localparam int NW = $clog2(MAX_IMAGE_SIZE + 1);
  localparam int EW = ((NW > SIZE_W) ? NW : SIZE_W) + 1;
  localparam logic [EW-1:0] K_E   = EW'(KERNEL_SIZE);
  localparam logic [EW-1:0] MAX_E = EW'(MAX_IMAGE_SIZE);
  localparam logic [EW-1:0] ONE_E = EW'(1);

  // position of the next pixel, and stride phase / quotient of the window origin
  logic [CW-1:0]       col, row;
  logic [STRIDE_W-1:0] cph, rph;
  logic [IDX_W-1:0]    cq, rq;

  logic [EW-1:0]       img_e, n_eff, col_e, row_e, s_e;
  logic [STRIDE_W-1:0] s_eff;
  logic                col_wrap, row_wrap, emit, last, in_acc;

  logic             a_vld, a_emit, a_adv;
  logic [PIX_W-1:0] a_pix;
  logic [CW-1:0]    a_col;
  meta_t            a_meta;

  logic [PIX_W-1:0] column   [KERNEL_SIZE];
  logic [PIX_W-1:0] win      [KERNEL_SIZE][KERNEL_SIZE];
  logic [PIX_W-1:0] win_next [KERNEL_SIZE][KERNEL_SIZE];

  assign img_e = EW'(cfg.image_size);
  assign n_eff = (img_e == '0) ? ONE_E : ((img_e > MAX_E) ? MAX_E : img_e);
  assign s_eff = (cfg.stride == '0) ? STRIDE_W'(1) : cfg.stride;
  assign col_e = EW'(col);
  assign row_e = EW'(row);
  assign s_e   = EW'(s_eff);

  assign col_wrap = (col_e + ONE_E) >= n_eff;
  assign row_wrap = (row_e + ONE_E) >= n_eff;

  assign emit = (n_eff >= K_E) && ((row_e + ONE_E) >= K_E) && ((col_e + ONE_E) >= K_E)
             && (rph == '0) && (cph == '0);
  // last origin is the one with no further stride step inside the image
  assign last = ((row_e + s_e) >= n_eff) && ((col_e + s_e) >= n_eff);

  assign a_adv     = a_vld && (!a_emit || !job_full);
  assign pix_ready = !a_vld || a_adv;
  assign in_acc    = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col <= '0;
      row <= '0;
      cph <= '0;
      rph <= '0;
      cq  <= '0;
      rq  <= '0;
    end else if (in_acc) begin
      if (col_wrap) begin
        col <= '0;
        cph <= '0;
        cq  <= '0;
        row <= row_wrap ? '0 : row + CW'(1);
        if (row_wrap || ((row_e + ONE_E) < K_E)) begin
          rph <= '0;
          rq  <= '0;
        end else if (rph == s_eff - STRIDE_W'(1)) begin
          rph <= '0;
          rq  <= rq + IDX_W'(1);
        end else begin
          rph <= rph + STRIDE_W'(1);
        end
      end else begin
        col <= col + CW'(1);
        if ((col_e + ONE_E) < K_E) begin
          cph <= '0;
          cq  <= '0;
        end else if (cph == s_eff - STRIDE_W'(1)) begin
          cph <= '0;
          cq  <= cq + IDX_W'(1);
        end else begin
          cph <= cph + STRIDE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (pix_ready) begin
      a_vld <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pix  <= pix;
      a_col  <= col;
      a_emit <= emit;
      a_meta <= '{out_row: rq, out_col: cq, last: last};
    end
  end

  assign column[KERNEL_SIZE-1] = a_pix;

  // line memory m holds the row m+1 above the current one; read at accept,
  // written back shifted down one line when the pixel leaves stage A
  for (genvar m = 0; m < KERNEL_SIZE - 1; m++) begin : g_line
    logic [PIX_W-1:0] mem [MAX_IMAGE_SIZE];
    logic [PIX_W-1:0] rd;

    always_ff @(posedge clk) begin
      if (in_acc) begin
        rd <= mem[col];
      end
    end

    always_ff @(posedge clk) begin
      if (a_adv) begin
        mem[a_col] <= column[KERNEL_SIZE-1-m];
      end
    end

    assign column[KERNEL_SIZE-2-m] = rd;
  end

  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
        win_next[i][j] = win[i][j+1];
      end
      win_next[i][KERNEL_SIZE-1] = column[i];
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      win <= win_next;
    end
  end

  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        job_win[(i*KERNEL_SIZE+j)*PIX_W +: PIX_W] = win_next[i][j];
      end
    end
  end

  assign job_push = a_adv && a_emit;
  assign job_meta = a_meta;

endmodule

// ===== hw/rtl/cvs_fifo.sv =====
module cvs_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import cvs_pkg::*;

  logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QPTR_W:0]   cnt;

  assign full  = cnt == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = cnt == '0;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + QPTR_W'(1);
      end
      if (pop) begin
        rp <= rp + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule

// ===== hw/rtl/cvs_back.sv =====
module cvs_back #(
  parameter int KERNEL_SIZE = 3
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  cvs_pkg::kernel_t                                 kernel,
  input  logic                                             job_valid,
  output logic                                             job_pop,
  input  logic [KERNEL_SIZE*KERNEL_SIZE*cvs_pkg::PIX_W-1:0] job_win,
  input  cvs_pkg::meta_t                                   job_meta,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output logic [cvs_pkg::VALUE_W-1:0]                      out_value,
  output cvs_pkg::meta_t                                   out_meta
);
  import cvs_pkg::*;

  localparam int RW = PROD_W + $clog2(KERNEL_SIZE);
  localparam int SW = RW + $clog2(KERNEL_SIZE);

  logic p_vld, r_vld, t_vld, o_vld;
  logic ready_p, ready_r, ready_t, ready_o;

  logic signed [PROD_W-1:0] prod [KERNEL_SIZE][KERNEL_SIZE];
  logic signed [RW-1:0]     rsum [KERNEL_SIZE];
  logic signed [RW-1:0]     rsum_c [KERNEL_SIZE];
  logic signed [SW-1:0]     tsum, tsum_c;
  logic signed [ACC_W-1:0]  acc_ext, q;
  logic [VALUE_W-1:0]       sat;
  meta_t                    p_meta, r_meta, t_meta, o_meta;
  logic [VALUE_W-1:0]       o_value;

  assign ready_o = !o_vld || out_ready;
  assign ready_t = !t_vld || ready_o;
  assign ready_r = !r_vld || ready_t;
  assign ready_p = !p_vld || ready_r;
  assign job_pop = job_valid && ready_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      r_vld <= 1'b0;
      t_vld <= 1'b0;
      o_vld <= 1'b0;
    end else begin
      if (ready_p) p_vld <= job_valid;
      if (ready_r) r_vld <= p_vld;
      if (ready_t) t_vld <= r_vld;
      if (ready_o) o_vld <= t_vld;
    end
  end

  // one multiplier lane per kernel tap
  always_ff @(posedge clk) begin
    if (job_pop) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        for (int j = 0; j < KERNEL_SIZE; j++) begin
          prod[i][j] <= $signed(job_win[(i*KERNEL_SIZE+j)*PIX_W +: PIX_W])
                      * $signed(kernel[i][j*COEF_W +: COEF_W]);
        end
      end
      p_meta <= job_meta;
    end
  end

  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      rsum_c[i] = '0;
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        rsum_c[i] = rsum_c[i] + RW'(prod[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_r && p_vld) begin
      rsum   <= rsum_c;
      r_meta <= p_meta;
    end
  end

  always_comb begin
    tsum_c = '0;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      tsum_c = tsum_c + SW'(rsum[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ready_t && r_vld) begin
      tsum   <= tsum_c;
      t_meta <= r_meta;
    end
  end

  // Q14.22 -> Q16.8 with floor, then clamp to 24 bits
  assign acc_ext = ACC_W'(tsum);
  assign q       = acc_ext >>> FRAC_SHIFT;
  always_comb begin
    if (q > SAT_MAX) begin
      sat = SAT_MAX[VALUE_W-1:0];
    end else if (q < SAT_MIN) begin
      sat = SAT_MIN[VALUE_W-1:0];
    end else begin
      sat = q[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && t_vld) begin
      o_value <= sat;
      o_meta  <= t_meta;
    end
  end

  assign out_valid = o_vld;
  assign out_value = o_value;
  assign out_meta  = o_meta;

endmodule
